### rtl/core/prd_pkg.sv
// Shared types and constants for the pixel readout record decoder.
// Used by prd_in_stage, prd_decode and pixel_readout_record_decoder.
package prd_pkg;

  localparam int WordW  = 24;
  localparam int TdataW = 120;

  // id byte codes, bits 23:16 of a readout word
  localparam logic [7:0] ID_HEADER  = 8'hE9;
  localparam logic [7:0] ID_ADDRESS = 8'hEA;
  localparam logic [7:0] ID_VALUE   = 8'hEC;
  localparam logic [7:0] ID_SERVICE = 8'hEF;
  localparam logic [7:0] ID_TRIGGER = 8'hF8;

  localparam logic [8:0] MAX_ROW = 9'd336;
  localparam logic [6:0] MAX_COL = 7'd80;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_ADDRESS = 3'd1;
  localparam logic [2:0] KIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_SERVICE = 3'd3;
  localparam logic [2:0] KIND_TRIGGER = 3'd4;
  localparam logic [2:0] KIND_HIT     = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  typedef struct packed {
    logic [2:0]       record_kind;
    logic             flag_bit;
    logic [6:0]       id_or_code;
    logic [9:0]       bunch_or_count;
    logic [15:0]      register_word;
    logic [6:0]       pixel_column;
    logic [8:0]       pixel_row;
    logic [3:0]       tot_first;
    logic [3:0]       tot_second;
    logic [2:0]       trg_mode;
    logic [31:0]      trg_number;
    logic [WordW-1:0] raw_word;
  } rec_t;

endpackage

### rtl/core/pixel_readout_record_decoder.sv
// Path: a word passes through the input register (prd_in_stage) and then the output register,
// which is loaded only when it is free or its result is taken in the same cycle.
// Throughput: one word per cycle while out_tready is high; with a result waiting, only one
// more word is taken into the input register. A trigger record takes two words.
// Reset (synchronous, rst_n low): clears valids and trigger state, mode = 1.
// Depends on prd_pkg, prd_in_stage and prd_decode.
module pixel_readout_record_decoder
  import prd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,   // fe_i4b_mode
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,      // [23:0] readout word
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] flag_bit, [7:1] id_or_code, [17:8] bunch_or_count, [33:18] register_word,
  // [40:34] pixel_column, [49:41] pixel_row, [53:50] tot_first, [57:54] tot_second,
  // [60:58] trg_mode, [92:61] trg_number, [116:93] raw_word, [119:117] zero
  output logic [TdataW-1:0] out_tdata,
  output logic [2:0]        out_tuser      // [2:0] record_kind
);

  logic             mode_r;
  logic             s1_valid;
  logic [WordW-1:0] s1_word;
  logic             adv;
  logic             emit;
  rec_t             rec;
  rec_t             out_r;
  logic             out_valid_r, out_valid_nxt;

  assign adv = s1_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  prd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_word  (in_tdata),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  prd_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv),
    .word   (s1_word),
    .fe_mode(mode_r),
    .emit   (emit),
    .rec    (rec)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_r <= rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.record_kind;
  assign out_tdata  = {3'b000, out_r.raw_word, out_r.trg_number, out_r.trg_mode,
                       out_r.tot_second, out_r.tot_first, out_r.pixel_row,
                       out_r.pixel_column, out_r.register_word, out_r.bunch_or_count,
                       out_r.id_or_code, out_r.flag_bit};

  property p_no_overwrite;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r && !out_tready |=> out_valid_r && $stable(out_r);
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("pending result overwritten");

  property p_result_from_stage;
    @(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> $past(adv) && $past(emit);
  endproperty
  a_result_from_stage: assert property (p_result_from_stage)
    else $error("result appeared without a decoded word");

  property p_accept_while_waiting;
    @(posedge clk) disable iff (!rst_n)
      !s1_valid |-> in_tready;
  endproperty
  a_accept_while_waiting: assert property (p_accept_while_waiting)
    else $error("input blocked with empty stage");

endmodule

### rtl/core/prd_in_stage.sv
// Input register stage: captures one readout word per transfer.
// Depends on prd_pkg for the word width.
module prd_in_stage
  import prd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [WordW-1:0] in_word,
  input  logic             adv,
  output logic             s1_valid,
  output logic [WordW-1:0] s1_word
);

  logic             valid_r, valid_nxt;
  logic [WordW-1:0] word_r;
  logic             take;

  assign in_tready = !valid_r || adv;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= in_word;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;

  property p_hold_when_blocked;
    @(posedge clk) disable iff (!rst_n)
      valid_r && !adv |=> valid_r && $stable(word_r);
  endproperty
  a_hold_when_blocked: assert property (p_hold_when_blocked)
    else $error("stage-1 word lost while blocked");

endmodule

### rtl/core/prd_decode.sv
// Record decoder: classifies a word, extracts fields, and holds the first
// word of a trigger record. Depends on prd_pkg for codes and rec_t.
module prd_decode
  import prd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [WordW-1:0] word,
  input  logic             fe_mode,
  output logic             emit,
  output rec_t             rec
);

  logic             pending_r, pending_nxt;
  logic [7:0]       high_r;
  logic [2:0]       mode_r;
  logic [4:0]       err_r;
  logic [WordW-1:0] first_r;
  logic [7:0]       id;
  logic [6:0]       col;
  logic [8:0]       row;
  logic             bad_addr;
  logic             hold_first;

  assign id  = word[23:16];
  assign col = word[23:17];
  assign row = word[16:8];
  assign bad_addr = (row > MAX_ROW) || (row == 9'd0) || (col > MAX_COL) || (col == 7'd0);

  assign hold_first = !pending_r && (id == ID_TRIGGER);
  assign emit       = !hold_first;

  always_comb begin
    rec = '0;
    rec.raw_word = word;
    if (pending_r) begin
      rec.record_kind = KIND_TRIGGER;
      rec.id_or_code  = {2'b00, err_r};
      rec.trg_mode    = mode_r;
      rec.trg_number  = {high_r, word};
      rec.raw_word    = first_r;
    end else begin
      unique case (id)
        ID_HEADER: begin
          rec.record_kind = KIND_HEADER;
          rec.flag_bit    = word[15];
          if (fe_mode) begin
            rec.id_or_code     = {2'b00, word[14:10]};
            rec.bunch_or_count = word[9:0];
          end else begin
            rec.id_or_code     = word[14:8];
            rec.bunch_or_count = {2'b00, word[7:0]};
          end
        end
        ID_ADDRESS: begin
          rec.record_kind   = KIND_ADDRESS;
          rec.flag_bit      = word[15];
          rec.register_word = {1'b0, word[14:0]};
        end
        ID_VALUE: begin
          rec.record_kind   = KIND_VALUE;
          rec.register_word = word[15:0];
        end
        ID_SERVICE: begin
          rec.record_kind    = KIND_SERVICE;
          rec.id_or_code     = {1'b0, word[15:10]};
          rec.bunch_or_count = word[9:0];
        end
        ID_TRIGGER: begin
          rec = '0;
        end
        default: begin
          if (bad_addr) begin
            rec.record_kind = KIND_ERROR;
          end else begin
            rec.record_kind  = KIND_HIT;
            rec.pixel_column = col;
            rec.pixel_row    = row;
            rec.tot_first    = word[7:4];
            rec.tot_second   = word[3:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    pending_nxt = pending_r;
    if (fire) begin
      pending_nxt = hold_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      high_r    <= '0;
      mode_r    <= '0;
      err_r     <= '0;
      first_r   <= '0;
    end else begin
      pending_r <= pending_nxt;
      // capture the first trigger word; the next word completes the record
      if (fire && hold_first) begin
        high_r  <= word[7:0];
        mode_r  <= word[15:13];
        err_r   <= word[12:8];
        first_r <= word;
      end
    end
  end

  property p_trigger_arms;
    @(posedge clk) disable iff (!rst_n)
      fire && !pending_r && (id == ID_TRIGGER) |=> pending_r && (first_r == $past(word));
  endproperty
  a_trigger_arms: assert property (p_trigger_arms)
    else $error("trigger word did not arm pending state");

  property p_trigger_completes;
    @(posedge clk) disable iff (!rst_n)
      fire && pending_r |-> emit && (rec.record_kind == KIND_TRIGGER) ##1 !pending_r;
  endproperty
  a_trigger_completes: assert property (p_trigger_completes)
    else $error("second trigger word did not complete record");

  property p_idle_keeps_state;
    @(posedge clk) disable iff (!rst_n)
      !fire |=> $stable(pending_r) && $stable(first_r);
  endproperty
  a_idle_keeps_state: assert property (p_idle_keeps_state)
    else $error("trigger state changed without a word");

endmodule

### test/pixel_readout_record_decoder_test.sv
// Self-checking testbench for pixel_readout_record_decoder: directed table, then random
// readout words under three idling patterns, checked against an in-bench record decoder.
// Depends on prd_pkg and the decoder RTL.
module pixel_readout_record_decoder_test
  import prd_pkg::*;
();

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [23:0]       in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [TdataW-1:0] out_tdata;
  logic [2:0]        out_tuser;

  pixel_readout_record_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  typedef enum bit {ROW_WORD, ROW_MODE} row_op_t;

  typedef struct {
    row_op_t     op;
    logic [23:0] word;
    bit          typed;
    rec_t        want;
  } dir_row_t;

  // decoder image: header layout select and the held first trigger word
  logic        mode_newer;
  logic        trig_pending;
  logic [7:0]  trig_high;
  logic [2:0]  trig_mode;
  logic [4:0]  trig_err;
  logic [23:0] trig_word;

  rec_t     expected_recs[$];
  dir_row_t dir_rows[$];
  int       send_idle;
  int       recv_idle;
  int       words_sent;
  int       recs_seen;
  int       fail_count;
  int       kind_count[8];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decode one accepted word; returns 1 when a record comes out of it.
  function automatic bit decode_word(input logic [23:0] w, output rec_t r);
    logic [6:0] col;
    logic [8:0] row;
    r = '0;
    col = w[23:17];
    row = w[16:8];
    if (trig_pending) begin
      trig_pending  = 1'b0;
      r.record_kind = KIND_TRIGGER;
      r.id_or_code  = {2'b00, trig_err};
      r.trg_mode    = trig_mode;
      r.trg_number  = {trig_high, w};
      r.raw_word    = trig_word;
      return 1'b1;
    end
    r.raw_word = w;
    case (w[23:16])
      ID_HEADER: begin
        r.record_kind = KIND_HEADER;
        r.flag_bit    = w[15];
        if (mode_newer) begin
          r.id_or_code     = {2'b00, w[14:10]};
          r.bunch_or_count = w[9:0];
        end else begin
          r.id_or_code     = w[14:8];
          r.bunch_or_count = {2'b00, w[7:0]};
        end
      end
      ID_ADDRESS: begin
        r.record_kind   = KIND_ADDRESS;
        r.flag_bit      = w[15];
        r.register_word = {1'b0, w[14:0]};
      end
      ID_VALUE: begin
        r.record_kind   = KIND_VALUE;
        r.register_word = w[15:0];
      end
      ID_SERVICE: begin
        r.record_kind    = KIND_SERVICE;
        r.id_or_code     = {1'b0, w[15:10]};
        r.bunch_or_count = w[9:0];
      end
      ID_TRIGGER: begin
        trig_pending = 1'b1;
        trig_mode    = w[15:13];
        trig_err     = w[12:8];
        trig_high    = w[7:0];
        trig_word    = w;
        return 1'b0;
      end
      default: begin
        if (row == 9'd0 || row > MAX_ROW || col == 7'd0 || col > MAX_COL) begin
          r.record_kind = KIND_ERROR;
        end else begin
          r.record_kind  = KIND_HIT;
          r.pixel_column = col;
          r.pixel_row    = row;
          r.tot_first    = w[7:4];
          r.tot_second   = w[3:0];
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic rec_t bad_hit(input logic [23:0] w);
    return rec_t'{record_kind: KIND_ERROR, raw_word: w, default: '0};
  endfunction

  function automatic void add_row(input row_op_t op, input logic [23:0] word,
                                  input bit typed = 1'b0, input rec_t want = '0);
    dir_row_t row_e;
    row_e.op    = op;
    row_e.word  = word;
    row_e.typed = typed;
    row_e.want  = want;
    dir_rows = {dir_rows, row_e};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one word, hold it until the transfer, then predict its record.
  task automatic push_word(input logic [23:0] w, input bit typed = 1'b0,
                           input rec_t want = '0);
    rec_t r;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (in_tready !== 1'b1);
    words_sent++;
    if (decode_word(w, r)) expected_recs = {expected_recs, (typed ? want : r)};
  endtask

  // Hold the input until every expected record is out, plus pipeline slack.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    mode_newer   = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random(input int n);
    logic [7:0]  special_ids[5] = '{ID_HEADER, ID_ADDRESS, ID_VALUE, ID_SERVICE, ID_TRIGGER};
    logic [6:0]  edge_cols[4] = '{7'd0, 7'd1, 7'd80, 7'd81};
    logic [8:0]  edge_rows[4] = '{9'd0, 9'd1, 9'd336, 9'd337};
    logic [23:0] follow;
    int          sent;
    int          pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        push_word({ID_HEADER, 16'($urandom)});
      end else if (pick < 23) begin
        push_word({ID_ADDRESS, 16'($urandom)});
      end else if (pick < 31) begin
        push_word({ID_VALUE, 16'($urandom)});
      end else if (pick < 39) begin
        push_word({ID_SERVICE, 16'($urandom)});
      end else if (pick < 54) begin
        // the follower is always the low trigger part, even when it looks like a record
        follow = 24'($urandom);
        if ($urandom_range(1) == 1) follow[23:16] = special_ids[$urandom_range(4)];
        push_word({ID_TRIGGER, 16'($urandom)});
        push_word(follow);
        sent++;
      end else if (pick < 82) begin
        push_word({7'($urandom_range(80, 1)), 9'($urandom_range(336, 1)), 8'($urandom)});
      end else if (pick < 90) begin
        push_word({edge_cols[$urandom_range(3)], edge_rows[$urandom_range(3)],
                   8'($urandom)});
      end else begin
        push_word(24'($urandom));
      end
      sent++;
    end
  endtask

  // Receiver: random backpressure and in-order comparison of every record transfer.
  always @(posedge clk) begin : record_check
    rec_t got;
    rec_t want;
    out_tready <= ($urandom_range(99) >= recv_idle);
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.record_kind    = out_tuser;
      got.flag_bit       = out_tdata[0];
      got.id_or_code     = out_tdata[7:1];
      got.bunch_or_count = out_tdata[17:8];
      got.register_word  = out_tdata[33:18];
      got.pixel_column   = out_tdata[40:34];
      got.pixel_row      = out_tdata[49:41];
      got.tot_first      = out_tdata[53:50];
      got.tot_second     = out_tdata[57:54];
      got.trg_mode       = out_tdata[60:58];
      got.trg_number     = out_tdata[92:61];
      got.raw_word       = out_tdata[116:93];
      recs_seen++;
      kind_count[got.record_kind]++;
      if (expected_recs.size() == 0) begin
        $error("unexpected record: kind %0d raw 0x%0h", got.record_kind, got.raw_word);
        fail_count++;
      end else begin
        want = expected_recs.pop_front();
        check_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
        check_field("flag_bit", 32'(want.flag_bit), 32'(got.flag_bit));
        check_field("id_or_code", 32'(want.id_or_code), 32'(got.id_or_code));
        check_field("bunch_or_count", 32'(want.bunch_or_count), 32'(got.bunch_or_count));
        check_field("register_word", 32'(want.register_word), 32'(got.register_word));
        check_field("pixel_column", 32'(want.pixel_column), 32'(got.pixel_column));
        check_field("pixel_row", 32'(want.pixel_row), 32'(got.pixel_row));
        check_field("tot_first", 32'(want.tot_first), 32'(got.tot_first));
        check_field("tot_second", 32'(want.tot_second), 32'(got.tot_second));
        check_field("trg_mode", 32'(want.trg_mode), 32'(got.trg_mode));
        check_field("trg_number", want.trg_number, got.trg_number);
        check_field("raw_word", 32'(want.raw_word), 32'(got.raw_word));
        if (|out_tdata[119:117]) begin
          $error("out_tdata pad: expected 0x0, got 0x%0h", out_tdata[119:117]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #1600000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int wait_cycles;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    mode_newer   = 1'b1;
    trig_pending = 1'b0;
    trig_high    = '0;
    trig_mode    = '0;
    trig_err     = '0;
    trig_word    = '0;
    send_idle    = 17;
    recv_idle    = 52;
    words_sent   = 0;
    recs_seen    = 0;
    fail_count   = 0;

    // header layout after reset is the newer one
    add_row(ROW_WORD, 24'hE9FFFF, 1'b1, rec_t'{record_kind: KIND_HEADER, flag_bit: 1'b1,
            id_or_code: 7'h1f, bunch_or_count: 10'h3ff, raw_word: 24'hE9FFFF, default: '0});
    add_row(ROW_WORD, 24'hE90000, 1'b1,
            rec_t'{record_kind: KIND_HEADER, raw_word: 24'hE90000, default: '0});
    add_row(ROW_WORD, 24'hEAFFFF, 1'b1, rec_t'{record_kind: KIND_ADDRESS, flag_bit: 1'b1,
            register_word: 16'h7fff, raw_word: 24'hEAFFFF, default: '0});
    add_row(ROW_WORD, 24'hEA0000, 1'b1,
            rec_t'{record_kind: KIND_ADDRESS, raw_word: 24'hEA0000, default: '0});
    add_row(ROW_WORD, 24'hECFFFF, 1'b1, rec_t'{record_kind: KIND_VALUE,
            register_word: 16'hffff, raw_word: 24'hECFFFF, default: '0});
    add_row(ROW_WORD, 24'hEC0000, 1'b1,
            rec_t'{record_kind: KIND_VALUE, raw_word: 24'hEC0000, default: '0});
    add_row(ROW_WORD, 24'hEFFFFF, 1'b1, rec_t'{record_kind: KIND_SERVICE, id_or_code: 7'h3f,
            bunch_or_count: 10'h3ff, raw_word: 24'hEFFFFF, default: '0});
    add_row(ROW_WORD, 24'hEF0000, 1'b1,
            rec_t'{record_kind: KIND_SERVICE, raw_word: 24'hEF0000, default: '0});
    // trigger pairs; the second word is always the low part
    add_row(ROW_WORD, 24'hF8FFFF);
    add_row(ROW_WORD, 24'h000000, 1'b1, rec_t'{record_kind: KIND_TRIGGER, id_or_code: 7'h1f,
            trg_mode: 3'h7, trg_number: 32'hFF000000, raw_word: 24'hF8FFFF,
            default: '0});
    add_row(ROW_WORD, 24'hF80000);
    add_row(ROW_WORD, 24'hE9ABCD, 1'b1, rec_t'{record_kind: KIND_TRIGGER,
            trg_number: 32'h00E9ABCD, raw_word: 24'hF80000, default: '0});
    add_row(ROW_WORD, 24'hF8A55A);
    add_row(ROW_WORD, 24'hF81234);
    // hit address corners, good and bad
    add_row(ROW_WORD, 24'h020100);
    add_row(ROW_WORD, 24'hA150FF);
    add_row(ROW_WORD, 24'h020000, 1'b1, bad_hit(24'h020000));
    add_row(ROW_WORD, 24'h035100, 1'b1, bad_hit(24'h035100));
    add_row(ROW_WORD, 24'h000100, 1'b1, bad_hit(24'h000100));
    add_row(ROW_WORD, 24'hA20100, 1'b1, bad_hit(24'hA20100));
    add_row(ROW_WORD, 24'hFFFFFF, 1'b1, bad_hit(24'hFFFFFF));
    add_row(ROW_WORD, 24'h000000, 1'b1, bad_hit(24'h000000));
    // older header layout
    add_row(ROW_MODE, 24'h000000);
    add_row(ROW_WORD, 24'hE9FFFF, 1'b1, rec_t'{record_kind: KIND_HEADER, flag_bit: 1'b1,
            id_or_code: 7'h7f, bunch_or_count: 10'h0ff, raw_word: 24'hE9FFFF, default: '0});
    add_row(ROW_WORD, 24'hE95A3C);
    add_row(ROW_MODE, 24'h000001);
    add_row(ROW_WORD, 24'hE97C01);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_MODE) begin
        write_mode(dir_rows[i].word[0]);
      end else begin
        push_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    write_mode(1'b0);
    send_random(520);

    send_idle = 52;
    recv_idle = 17;
    write_mode(1'b1);
    send_random(520);

    send_idle = 0;
    recv_idle = 0;
    write_mode(1'b0);
    send_random(260);
    drain();
    send_random(250);

    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (expected_recs.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_recs.size() != 0) begin
      $error("%0d expected records never arrived", expected_recs.size());
      fail_count++;
    end

    $display("Run: %0d words in, %0d records out under both header layouts", words_sent,
             recs_seen);
    $display("Records by kind: hdr %0d addr %0d val %0d svc %0d trig %0d hit %0d err %0d",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4],
             kind_count[5], kind_count[6]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### pixel_readout_record_decoder.f
rtl/core/prd_pkg.sv
rtl/core/prd_in_stage.sv
rtl/core/prd_decode.sv
rtl/core/pixel_readout_record_decoder.sv
test/pixel_readout_record_decoder_test.sv
